>>> rtl/rdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_pkg
// Types and constants shared by the ROM dialect classifier modules.
// ----------------------------------------------------------------------------
package rdc_pkg;

    // Input item kinds (s_axis_tuser)
    localparam logic [1:0] REQ_WORD  = 2'd0;
    localparam logic [1:0] REQ_BYTE  = 2'd1;
    localparam logic [1:0] REQ_EMPTY = 2'd2;

    // Dialect codes, signed 3 bits
    localparam logic signed [2:0] DIALECT_EMPTY    = -3'sd1;
    localparam logic signed [2:0] DIALECT_BASE     = 3'sd0;
    localparam logic signed [2:0] DIALECT_ALTERNATE = 3'sd1;
    localparam logic signed [2:0] DIALECT_EXTENDED = 3'sd2;

    // Quirk profiles
    localparam logic [1:0] PROFILE_MODERN    = 2'd0;
    localparam logic [1:0] PROFILE_ORIGINAL  = 2'd1;
    localparam logic [1:0] PROFILE_ALTERNATE = 2'd2;

    // Confidence figures (percent)
    localparam logic [6:0] CONF_NEUTRAL   = 7'd55;
    localparam logic [6:0] CONF_EXT_BASE  = 7'd88;
    localparam logic [6:0] CONF_EXT_CAP   = 7'd99;
    localparam logic [6:0] CONF_ALT_BASE  = 7'd62;
    localparam logic [6:0] CONF_ALT_CAP   = 7'd90;
    localparam logic [6:0] CONF_ORIG_BASE = 7'd60;
    localparam logic [6:0] CONF_ORIG_CAP  = 7'd88;

    // Evidence weights
    localparam logic [1:0] WEIGHT_CALL  = 2'd3;
    localparam logic [1:0] WEIGHT_SHIFT = 2'd2;
    localparam logic [1:0] WEIGHT_JUMP  = 2'd3;

    localparam int EXT_W   = 12;
    localparam int SCORE_W = 13;
    localparam logic [EXT_W-1:0]   EXT_MAX   = '1;
    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

    typedef struct packed {
        logic       ext_hit;
        logic [1:0] orig_add;
        logic [1:0] alt_add;
    } decode_t;

    // Packed so that dialect sits in the lowest bits
    typedef struct packed {
        logic [5:0]         pad;
        logic [SCORE_W-1:0] alternate_hits;
        logic [SCORE_W-1:0] original_hits;
        logic [EXT_W-1:0]   extended_hits;
        logic [6:0]         confidence;
        logic [1:0]         profile;
        logic signed [2:0]  dialect;
    } result_t;

endpackage

>>> rtl/rdc_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_decode
// Matches one instruction word against the dialect signatures and returns
// the evidence it adds.
// ----------------------------------------------------------------------------
module rdc_decode (
    input  logic [1:0]           req_type,
    input  logic [15:0]          opcode,
    output rdc_pkg::decode_t     dec
);
    import rdc_pkg::*;

    logic [3:0] top;
    logic [3:0] x;
    logic [3:0] y;
    logic [3:0] n;
    logic [7:0] low;
    logic       is_word;
    logic       ext_match;
    logic       call_match;
    logic       shift_match;
    logic       jump_match;

    assign top = opcode[15:12];
    assign x   = opcode[11:8];
    assign y   = opcode[7:4];
    assign n   = opcode[3:0];
    assign low = opcode[7:0];

    assign is_word = (req_type == REQ_WORD);

    // 00FB..00FF, 00Cn, Dxy0, Fx30/Fx75/Fx85
    assign ext_match = ((opcode[15:8] == 8'h00) && (low >= 8'hFB))
                    || ((opcode & 16'hFFF0) == 16'h00C0)
                    || ((opcode & 16'hF00F) == 16'hD000)
                    || ((top == 4'hF) && (low == 8'h30 || low == 8'h75 || low == 8'h85));

    assign call_match  = (top == 4'h0) && (opcode != 16'h0000)
                      && (opcode != 16'h00E0) && (opcode != 16'h00EE);
    assign shift_match = (top == 4'h8) && (n == 4'h6 || n == 4'hE) && (x != y);
    assign jump_match  = (top == 4'hB) && (x != 4'h0);

    // call and shift have different top nibbles, so at most one applies
    always_comb
    begin
        dec = '0;
        if (is_word)
        begin
            if (ext_match)
            begin
                dec.ext_hit = 1'b1;
            end
            else
            begin
                if (call_match)
                begin
                    dec.orig_add = WEIGHT_CALL;
                end
                else if (shift_match)
                begin
                    dec.orig_add = WEIGHT_SHIFT;
                end
                if (jump_match)
                begin
                    dec.alt_add = WEIGHT_JUMP;
                end
            end
        end
    end

endmodule

>>> rtl/rdc_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_accum
// Saturating evidence counters and end-of-image classification.
// ----------------------------------------------------------------------------
module rdc_accum (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic [1:0]           req_type,
    input  logic                 last,
    input  rdc_pkg::decode_t     dec,
    output logic                 emit,
    output rdc_pkg::result_t     result
);
    import rdc_pkg::*;

    logic [EXT_W-1:0]   ext_reg;
    logic [SCORE_W-1:0] orig_reg;
    logic [SCORE_W-1:0] alt_reg;
    logic [EXT_W-1:0]   ext_next;
    logic [SCORE_W-1:0] orig_next;
    logic [SCORE_W-1:0] alt_next;

    logic [EXT_W:0]     ext_sum;
    logic [SCORE_W:0]   orig_sum;
    logic [SCORE_W:0]   alt_sum;
    logic [SCORE_W:0]   ext_conf;
    logic [SCORE_W+2:0] alt_conf;
    logic [SCORE_W+2:0] orig_conf;
    logic               is_empty;

    assign is_empty = (req_type == REQ_EMPTY);
    assign emit     = is_empty || last;

    assign ext_sum  = {1'b0, ext_reg} + (EXT_W + 1)'(dec.ext_hit);
    assign orig_sum = {1'b0, orig_reg} + (SCORE_W + 1)'(dec.orig_add);
    assign alt_sum  = {1'b0, alt_reg} + (SCORE_W + 1)'(dec.alt_add);

    assign ext_next  = ext_sum[EXT_W] ? EXT_MAX : ext_sum[EXT_W-1:0];
    assign orig_next = (orig_sum > {1'b0, SCORE_MAX}) ? SCORE_MAX : orig_sum[SCORE_W-1:0];
    assign alt_next  = (alt_sum > {1'b0, SCORE_MAX}) ? SCORE_MAX : alt_sum[SCORE_W-1:0];

    assign ext_conf  = (SCORE_W + 1)'(CONF_EXT_BASE) + (SCORE_W + 1)'({ext_next, 1'b0});
    assign alt_conf  = (SCORE_W + 3)'(CONF_ALT_BASE) + (SCORE_W + 3)'({alt_next, 2'b00});
    assign orig_conf = (SCORE_W + 3)'(CONF_ORIG_BASE) + (SCORE_W + 3)'({orig_next, 2'b00});

    always_comb
    begin
        result                = '0;
        result.extended_hits  = ext_next;
        result.original_hits  = orig_next;
        result.alternate_hits = alt_next;
        if (is_empty)
        begin
            result.dialect        = DIALECT_EMPTY;
            result.profile        = PROFILE_MODERN;
            result.confidence     = CONF_NEUTRAL;
            result.extended_hits  = '0;
            result.original_hits  = '0;
            result.alternate_hits = '0;
        end
        else if (ext_next != '0)
        begin
            result.dialect    = DIALECT_EXTENDED;
            result.profile    = PROFILE_ALTERNATE;
            result.confidence = (ext_conf > (SCORE_W + 1)'(CONF_EXT_CAP))
                              ? CONF_EXT_CAP : ext_conf[6:0];
        end
        else if ({1'b0, alt_next} >= {1'b0, orig_next} + (SCORE_W + 1)'(2))
        begin
            result.dialect    = DIALECT_ALTERNATE;
            result.profile    = PROFILE_ALTERNATE;
            result.confidence = (alt_conf > (SCORE_W + 3)'(CONF_ALT_CAP))
                              ? CONF_ALT_CAP : alt_conf[6:0];
        end
        else if ({1'b0, orig_next} >= {1'b0, alt_next} + (SCORE_W + 1)'(2))
        begin
            result.dialect    = DIALECT_BASE;
            result.profile    = PROFILE_ORIGINAL;
            result.confidence = (orig_conf > (SCORE_W + 3)'(CONF_ORIG_CAP))
                              ? CONF_ORIG_CAP : orig_conf[6:0];
        end
        else
        begin
            result.dialect    = DIALECT_BASE;
            result.profile    = PROFILE_MODERN;
            result.confidence = CONF_NEUTRAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg  <= '0;
            orig_reg <= '0;
            alt_reg  <= '0;
        end
        else if (fire)
        begin
            if (emit)
            begin
                ext_reg  <= '0;
                orig_reg <= '0;
                alt_reg  <= '0;
            end
            else
            begin
                ext_reg  <= ext_next;
                orig_reg <= orig_next;
                alt_reg  <= alt_next;
            end
        end
    end

endmodule

>>> rtl/rom_dialect_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rom_dialect_classifier_unit
// Streams a program image word by word and reports its dialect and quirk
// profile at the end of each image.
// ----------------------------------------------------------------------------
// One instruction word is taken per clock. An item goes into an input
// register, from which it is decoded and folded into the saturating
// counters, and on the item marked last (or an empty-image marker) the
// classification lands in the output register that drives m_axis. The
// output register lets the input side keep taking items while a result
// waits; input stalls only when a second result is due and the first has
// not been taken.
module rom_dialect_classifier_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] opcode
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] dialect, [4:3] profile, [11:5] confidence, [23:12] extended_hits,
    // [36:24] original_hits, [49:37] alternate_hits, [55:50] zero
    output logic [55:0] m_axis_tdata
);
    import rdc_pkg::*;

    logic        in_valid_reg;
    logic [1:0]  in_type_reg;
    logic [15:0] in_op_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    result_t     out_data_reg;

    decode_t     dec;
    result_t     result;
    logic        emit;
    logic        slot_free;
    logic        advance;
    logic        in_load;

    rdc_decode u_decode (
        .req_type (in_type_reg),
        .opcode   (in_op_reg),
        .dec      (dec)
    );

    rdc_accum u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (advance),
        .req_type (in_type_reg),
        .last     (in_last_reg),
        .dec      (dec),
        .emit     (emit),
        .result   (result)
    );

    assign slot_free     = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!emit || slot_free);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_load)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_type_reg <= s_axis_tuser;
            in_op_reg   <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

>>> rtl/rdc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_checker
// Port-level checks on the classifier result stream.
// ----------------------------------------------------------------------------
module rdc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);
    import rdc_pkg::*;

    logic [2:0]  dialect;
    logic [6:0]  confidence;
    logic [11:0] ext_hits;
    logic [12:0] orig_hits;
    logic [12:0] alt_hits;

    assign dialect    = m_axis_tdata[2:0];
    assign confidence = m_axis_tdata[11:5];
    assign ext_hits   = m_axis_tdata[23:12];
    assign orig_hits  = m_axis_tdata[36:24];
    assign alt_hits   = m_axis_tdata[49:37];

    // stalled transfer keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_conf_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> confidence >= CONF_NEUTRAL && confidence <= CONF_EXT_CAP)
        else $error("confidence out of range");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && dialect == DIALECT_EMPTY |->
            ext_hits == '0 && orig_hits == '0 && alt_hits == '0
            && confidence == CONF_NEUTRAL)
        else $error("empty image result carries counts");

    a_extended: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && dialect != DIALECT_EMPTY |->
            ((dialect == DIALECT_EXTENDED) == (ext_hits != '0)))
        else $error("extended dialect does not match extended count");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[55:50] == '0)
        else $error("nonzero pad bits");

endmodule

bind rom_dialect_classifier_unit rdc_checker u_rdc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> dv/rdc_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_tb_pkg
// Opcode fields and item kinds shared by the classifier testbench files.
// ----------------------------------------------------------------------------
package rdc_tb_pkg;

    // Item kind that the block treats like a lone trailing byte
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Top nibble of an instruction word
    localparam logic [3:0] OP_SYS      = 4'h0;
    localparam logic [3:0] OP_ALU      = 4'h8;
    localparam logic [3:0] OP_JUMP_OFS = 4'hB;
    localparam logic [3:0] OP_DRAW     = 4'hD;
    localparam logic [3:0] OP_MISC     = 4'hF;

    // ALU sub-ops (low nibble)
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SHL = 4'hE;

    // System words
    localparam logic [15:0] SYS_NOP         = 16'h0000;
    localparam logic [15:0] SYS_CLS         = 16'h00E0;
    localparam logic [15:0] SYS_RET         = 16'h00EE;
    localparam logic [15:0] SYS_EXT_FIRST   = 16'h00FB;
    localparam logic [15:0] SYS_EXT_LAST    = 16'h00FF;
    localparam logic [11:0] SYS_SCROLL_DOWN = 12'h00C;

    // Extended Fx-- low bytes
    localparam logic [7:0] MISC_BIG_FONT   = 8'h30;
    localparam logic [7:0] MISC_SAVE_FLAGS = 8'h75;
    localparam logic [7:0] MISC_LOAD_FLAGS = 8'h85;

endpackage

>>> dv/rdc_verdict_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_verdict_monitor
// Watches both streams of the classifier, keeps its own dialect tallies for
// every accepted word, and compares each emitted verdict with the oldest one
// predicted.
// ----------------------------------------------------------------------------
module rdc_verdict_monitor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] opcode
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] dialect, [4:3] profile, [11:5] confidence, [23:12] extended_hits,
    // [36:24] original_hits, [49:37] alternate_hits, [55:50] zero
    input  logic [55:0] m_axis_tdata,
    output int          fail_count,
    output int          pending_results
);
    import rdc_pkg::*;
    import rdc_tb_pkg::*;

    localparam int SHOW_LIMIT = 10;

    logic [EXT_W-1:0]   ext_tally;
    logic [SCORE_W-1:0] orig_tally;
    logic [SCORE_W-1:0] alt_tally;
    result_t            expected_verdicts[$];

    function automatic logic is_extended_op(input logic [15:0] w);
        return (w >= SYS_EXT_FIRST && w <= SYS_EXT_LAST) ||
               (w[15:4] == SYS_SCROLL_DOWN) ||
               (w[15:12] == OP_DRAW && w[3:0] == 4'h0) ||
               (w[15:12] == OP_MISC && (w[7:0] == MISC_BIG_FONT ||
                                        w[7:0] == MISC_SAVE_FLAGS ||
                                        w[7:0] == MISC_LOAD_FLAGS));
    endfunction

    function automatic logic [SCORE_W-1:0] score_add(input logic [SCORE_W-1:0] s,
                                                     input logic [1:0] weight);
        int sum;
        sum = int'(s) + int'(weight);
        return (sum > int'(SCORE_MAX)) ? SCORE_MAX : SCORE_W'(sum);
    endfunction

    function automatic string show_verdict(input result_t r);
        return $sformatf("dialect %0d profile %0d conf %0d ext %0d orig %0d alt %0d pad %h",
                         r.dialect, r.profile, r.confidence, r.extended_hits,
                         r.original_hits, r.alternate_hits, r.pad);
    endfunction

    // Evidence from one full word; an extended hit shadows the other checks
    task automatic absorb_word(input logic [15:0] w);
        if (is_extended_op(w))
        begin
            if (ext_tally != EXT_MAX)
                ext_tally = ext_tally + 1'b1;
        end
        else
        begin
            if (w[15:12] == OP_SYS && w != SYS_NOP && w != SYS_CLS && w != SYS_RET)
                orig_tally = score_add(orig_tally, WEIGHT_CALL);
            if (w[15:12] == OP_ALU && (w[3:0] == ALU_SHR || w[3:0] == ALU_SHL) &&
                w[11:8] != w[7:4])
                orig_tally = score_add(orig_tally, WEIGHT_SHIFT);
            if (w[15:12] == OP_JUMP_OFS && w[11:8] != 4'h0)
                alt_tally = score_add(alt_tally, WEIGHT_JUMP);
        end
    endtask

    function automatic result_t form_verdict();
        result_t r;
        int ext;
        int orig;
        int alt;
        int conf;
        r = '0;
        ext = int'(ext_tally);
        orig = int'(orig_tally);
        alt = int'(alt_tally);
        if (ext > 0)
        begin
            r.dialect = DIALECT_EXTENDED;
            r.profile = PROFILE_ALTERNATE;
            conf = int'(CONF_EXT_BASE) + 2 * ext;
            if (conf > int'(CONF_EXT_CAP))
                conf = int'(CONF_EXT_CAP);
        end
        else if (alt >= orig + 2)
        begin
            r.dialect = DIALECT_ALTERNATE;
            r.profile = PROFILE_ALTERNATE;
            conf = int'(CONF_ALT_BASE) + 4 * alt;
            if (conf > int'(CONF_ALT_CAP))
                conf = int'(CONF_ALT_CAP);
        end
        else if (orig >= alt + 2)
        begin
            r.dialect = DIALECT_BASE;
            r.profile = PROFILE_ORIGINAL;
            conf = int'(CONF_ORIG_BASE) + 4 * orig;
            if (conf > int'(CONF_ORIG_CAP))
                conf = int'(CONF_ORIG_CAP);
        end
        else
        begin
            r.dialect = DIALECT_BASE;
            r.profile = PROFILE_MODERN;
            conf = int'(CONF_NEUTRAL);
        end
        r.confidence = 7'(conf);
        r.extended_hits = ext_tally;
        r.original_hits = orig_tally;
        r.alternate_hits = alt_tally;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            ext_tally = '0;
            orig_tally = '0;
            alt_tally = '0;
            expected_verdicts.delete();
            fail_count = 0;
            pending_results = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_verdicts.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= SHOW_LIMIT)
                        $display("%0t: unexpected result transfer, data %h", $time, got);
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (got.dialect !== want.dialect || got.profile !== want.profile ||
                        got.confidence !== want.confidence ||
                        got.extended_hits !== want.extended_hits ||
                        got.original_hits !== want.original_hits ||
                        got.alternate_hits !== want.alternate_hits ||
                        got.pad !== want.pad)
                    begin
                        fail_count++;
                        if (fail_count <= SHOW_LIMIT)
                        begin
                            $display("%0t: result mismatch, expected %s",
                                     $time, show_verdict(want));
                            $display("%0t:                   actual %s",
                                     $time, show_verdict(got));
                        end
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == REQ_EMPTY)
                begin
                    // empty marker reports regardless of tlast
                    want = '0;
                    want.dialect = DIALECT_EMPTY;
                    want.profile = PROFILE_MODERN;
                    want.confidence = CONF_NEUTRAL;
                    expected_verdicts.push_back(want);
                    ext_tally = '0;
                    orig_tally = '0;
                    alt_tally = '0;
                end
                else
                begin
                    if (s_axis_tuser == REQ_WORD)
                        absorb_word(s_axis_tdata);
                    if (s_axis_tlast)
                    begin
                        expected_verdicts.push_back(form_verdict());
                        ext_tally = '0;
                        orig_tally = '0;
                        alt_tally = '0;
                    end
                end
            end
            pending_results = expected_verdicts.size();
        end
    end

endmodule

>>> dv/tb_rom_dialect_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rom_dialect_classifier_unit
// Streams directed and random program images into the classifier with random
// gaps and stalls on both sides and a long output hold-off; a monitor
// predicts and checks each verdict.
// ----------------------------------------------------------------------------
module tb_rom_dialect_classifier_unit;
    import rdc_pkg::*;
    import rdc_tb_pkg::*;

    localparam int RANDOM_ITEMS   = 760;
    localparam int PRESSURE_ITEMS = 60;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 10;
    localparam int RUN_LIMIT_NS   = 10_000_000;

    typedef enum int {PICK_EXT, PICK_CALL, PICK_SHIFT, PICK_JUMP, PICK_ANY} pick_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [15:0] opcode
    logic [1:0]  s_axis_tuser;   // [1:0] req_type
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [2:0] dialect, [4:3] profile, [11:5] confidence, [23:12] extended_hits,
    // [36:24] original_hits, [49:37] alternate_hits, [55:50] zero
    logic [55:0] m_axis_tdata;

    int fail_count;
    int pending_results;
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_requests;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    rom_dialect_classifier_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rdc_verdict_monitor u_verdict_mon (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    function automatic logic [15:0] pick_word(input pick_t how);
        logic [15:0] w;
        w = 16'($urandom);
        case (how)
            PICK_EXT:
                case ($urandom_range(0, 3))
                    0: w = SYS_EXT_FIRST + 16'($urandom_range(0, 4));
                    1: w = {SYS_SCROLL_DOWN, w[3:0]};
                    2: w = {OP_DRAW, w[11:4], 4'h0};
                    default: w = {OP_MISC, w[11:8],
                                  w[0] ? MISC_BIG_FONT :
                                  (w[1] ? MISC_SAVE_FLAGS : MISC_LOAD_FLAGS)};
                endcase
            PICK_CALL:  w[15:12] = OP_SYS;
            PICK_SHIFT:
            begin
                w[15:12] = OP_ALU;
                w[3:0] = w[0] ? ALU_SHL : ALU_SHR;
            end
            PICK_JUMP:  w[15:12] = OP_JUMP_OFS;
            default: ;
        endcase
        return w;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input logic [1:0] kind, input logic [15:0] word,
                             input logic lst);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= word;
        s_axis_tuser <= kind;
        s_axis_tlast <= lst;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // One image biased toward one kind of evidence, with some noise items
    task automatic send_random_image(input int len);
        pick_t favored;
        pick_t how;
        int i;
        int roll;
        logic [1:0] kind;
        logic lst;
        favored = pick_t'($urandom_range(PICK_EXT, PICK_ANY));
        for (i = 0; i < len; i++)
        begin
            how = ($urandom_range(0, 99) < 70) ? favored :
                  pick_t'($urandom_range(PICK_CALL, PICK_ANY));
            lst = (i == len - 1);
            roll = $urandom_range(0, 99);
            if (roll < 4)
                kind = REQ_BYTE;
            else if (roll < 7)
                kind = REQ_UNUSED;
            else if (roll < 9)
                kind = REQ_EMPTY;
            else
                kind = REQ_WORD;
            if (lst && $urandom_range(0, 99) < 15)
                kind = REQ_BYTE;
            send_item(kind, pick_word(how), lst);
        end
    endtask

    // Output side: random stalls, plus one long hold-off on request
    initial
    begin
        int holds_served;
        holds_served = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served = hold_requests;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    initial
    begin
        int rand_sent;
        int len;
        int i;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = REQ_WORD;
        s_axis_tlast = 1'b0;
        tx_idle_pct = 22;
        rx_idle_pct = 70;
        hold_requests = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // extended opcodes of every form, capped confidence
        send_item(REQ_WORD, SYS_EXT_FIRST, 1'b0);
        send_item(REQ_WORD, SYS_EXT_LAST, 1'b0);
        send_item(REQ_WORD, {SYS_SCROLL_DOWN, 4'h7}, 1'b0);
        send_item(REQ_WORD, {OP_DRAW, 8'h5A, 4'h0}, 1'b0);
        send_item(REQ_WORD, {OP_MISC, 4'h1, MISC_BIG_FONT}, 1'b0);
        send_item(REQ_WORD, {OP_MISC, 4'hA, MISC_SAVE_FLAGS}, 1'b0);
        send_item(REQ_WORD, {OP_MISC, 4'hF, MISC_LOAD_FLAGS}, 1'b1);
        // original-machine evidence, excluded system words, same-register shift
        send_item(REQ_WORD, SYS_NOP, 1'b0);
        send_item(REQ_WORD, SYS_CLS, 1'b0);
        send_item(REQ_WORD, SYS_RET, 1'b0);
        send_item(REQ_WORD, {OP_SYS, 12'hFFF}, 1'b0);
        send_item(REQ_WORD, {OP_ALU, 4'h1, 4'h2, ALU_SHR}, 1'b0);
        send_item(REQ_WORD, {OP_ALU, 4'h1, 4'h2, ALU_SHL}, 1'b0);
        send_item(REQ_WORD, {OP_ALU, 4'h7, 4'h7, ALU_SHR}, 1'b0);
        send_item(REQ_WORD, 16'hFFFF, 1'b1);
        // offset jumps, register zero ignored, image closed by a trailing byte
        send_item(REQ_WORD, {OP_JUMP_OFS, 12'h100}, 1'b0);
        send_item(REQ_WORD, {OP_JUMP_OFS, 12'hF00}, 1'b0);
        send_item(REQ_WORD, {OP_JUMP_OFS, 12'h0FF}, 1'b0);
        send_item(REQ_BYTE, 16'h00AB, 1'b1);
        // empty marker without tlast, single-byte image, unused kind, empty marker
        send_item(REQ_EMPTY, 16'h0000, 1'b0);
        send_item(REQ_BYTE, 16'h00CD, 1'b1);
        send_item(REQ_UNUSED, SYS_EXT_FIRST, 1'b0);
        send_item(REQ_WORD, {OP_SYS, 12'h123}, 1'b1);
        send_item(REQ_EMPTY, 16'hFFFF, 1'b1);

        rand_sent = 0;
        while (rand_sent < RANDOM_ITEMS)
        begin
            if (rand_sent >= 2 * RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else if (rand_sent >= RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 70;
                rx_idle_pct = 22;
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            send_random_image(len);
            rand_sent += len;
        end

        // back-to-back one-word images against a stalled output
        hold_requests++;
        for (i = 0; i < PRESSURE_ITEMS; i++)
            send_item(REQ_WORD, pick_word(PICK_ANY), 1'b1);
        s_axis_tvalid <= 1'b0;

        while (pending_results != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
